// ===== rtl/core/sss_pkg.sv =====
// Shared constants, codes and controller/datapath types of the stall sensitivity search.
package sss_pkg;

  localparam int SENS_COUNT = 16;
  localparam int SENS_MIN   = 0;
  localparam int IDX_W      = $clog2(SENS_COUNT);
  localparam int MID_INDEX  = (SENS_MIN + SENS_MIN + SENS_COUNT - 1) / 2 - SENS_MIN;

  localparam int FUNC_W = 2;
  localparam int OFF_W  = 16;
  localparam int MEAN_W = 16;
  localparam int CNT_W  = 4;
  localparam int PROD_W = MEAN_W + CNT_W;
  localparam int LIM_W  = 16;
  localparam int TRY_W  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BEGIN      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BEGIN_DONE = 2'd2;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_BAD_LIMIT = 1'b0;
  localparam logic REG_TRIES     = 1'b1;
  localparam logic [LIM_W-1:0] BAD_LIMIT_RST = 16'd153;
  localparam logic [TRY_W-1:0] TRIES_RST     = 4'd4;

  // Datapath operations issued by the controller.
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT    = 5'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 5'd2;
  localparam logic [OP_W-1:0] OP_RD_CUR    = 5'd3;
  localparam logic [OP_W-1:0] OP_DIV       = 5'd4;
  localparam logic [OP_W-1:0] OP_WRITE     = 5'd5;
  localparam logic [OP_W-1:0] OP_MUL_CUR   = 5'd6;
  localparam logic [OP_W-1:0] OP_CHK_CUR   = 5'd7;
  localparam logic [OP_W-1:0] OP_RD_BEST   = 5'd8;
  localparam logic [OP_W-1:0] OP_UPD_BEST  = 5'd9;
  localparam logic [OP_W-1:0] OP_CHK_BEST  = 5'd10;
  localparam logic [OP_W-1:0] OP_STEP_UP   = 5'd11;
  localparam logic [OP_W-1:0] OP_STEP_DOWN = 5'd12;
  localparam logic [OP_W-1:0] OP_RD_MID    = 5'd13;
  localparam logic [OP_W-1:0] OP_MUL_RD    = 5'd14;
  localparam logic [OP_W-1:0] OP_STEP_MID  = 5'd15;
  localparam logic [OP_W-1:0] OP_SCAN_INIT = 5'd16;
  localparam logic [OP_W-1:0] OP_RD_SCAN   = 5'd17;
  localparam logic [OP_W-1:0] OP_SCAN_STEP = 5'd18;
  localparam logic [OP_W-1:0] OP_WALK_INIT = 5'd19;
  localparam logic [OP_W-1:0] OP_RD_WALK   = 5'd20;
  localparam logic [OP_W-1:0] OP_WALK_DEC  = 5'd21;
  localparam logic [OP_W-1:0] OP_FINAL     = 5'd22;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              fin;
    logic              div_busy;
    logic              prod_bad;
    logic              tries_hit;
    logic              cur_hi;
    logic              can_up;
    logic              can_down;
    logic              not_good;
    logic              scan_last;
    logic              first_zero;
    logic              walk_match;
  } dp_stat_t;

endpackage

// ===== rtl/core/sss_if.sv =====
// Handshake channels for input items and result items.
interface sss_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [sss_pkg::FUNC_W-1:0]          func;
  logic signed [sss_pkg::OFF_W-1:0]    homing_offset;

  modport source (output valid, output func, output homing_offset, input ready);
  modport sink   (input valid, input func, input homing_offset, output ready);
endinterface

interface sss_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [sss_pkg::IDX_W-1:0]  sensitivity_index;
  logic                       done_res;
  logic                       moved;

  modport source (output valid, output sensitivity_index, output done_res, output moved,
                  input ready);
  modport sink   (input valid, input sensitivity_index, input done_res, input moved,
                  output ready);
endinterface

// ===== rtl/core/sss_div.sv =====
// Restoring divider, one quotient bit per cycle, for the running-mean update.
module sss_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sss_pkg::MEAN_W-1:0]  dividend,
  input  logic [sss_pkg::CNT_W-1:0]   divisor,
  output logic                        busy,
  output logic [sss_pkg::MEAN_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(sss_pkg::MEAN_W);

  logic [sss_pkg::MEAN_W-1:0] work;
  logic [sss_pkg::CNT_W-1:0]  dvs;
  logic [sss_pkg::CNT_W-1:0]  rem;
  logic [STEP_W-1:0]          step;
  logic [sss_pkg::CNT_W:0]    rem_sh;
  logic                       ge;

  assign rem_sh   = {rem, work[sss_pkg::MEAN_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '1;
    end else if (busy) begin
      step <= step - 1'b1;
      if (step == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // The quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[sss_pkg::MEAN_W-2:0], ge};
      rem  <= ge ? sss_pkg::CNT_W'(rem_sh - {1'b0, dvs}) : rem_sh[sss_pkg::CNT_W-1:0];
    end
  end

endmodule

// ===== rtl/core/sss_dp.sv =====
// Datapath: setting tables, running-mean update, bad checks and final selection.
module sss_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  sss_pkg::dp_cmd_t                  cmd,
  output sss_pkg::dp_stat_t                 stat,
  input  logic [sss_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [sss_pkg::OFF_W-1:0]  in_offset,
  input  logic [sss_pkg::LIM_W-1:0]         bad_limit,
  input  logic [sss_pkg::TRY_W-1:0]         tries,
  output logic [sss_pkg::IDX_W-1:0]         cur_index,
  output logic                              finished,
  output logic                              moved
);

  localparam int IW = sss_pkg::IDX_W;
  localparam int MW = sss_pkg::MEAN_W;
  localparam int CW = sss_pkg::CNT_W;
  localparam logic [IW-1:0] MID  = IW'(sss_pkg::MID_INDEX);
  localparam logic [IW-1:0] TOP  = IW'(sss_pkg::SENS_COUNT - 1);

  // Setting tables; an entry not written since the last begin reads as zero.
  logic [MW-1:0] mean_mem [sss_pkg::SENS_COUNT];
  logic [CW-1:0] cnt_mem  [sss_pkg::SENS_COUNT];
  logic [sss_pkg::SENS_COUNT-1:0] vld;

  logic [sss_pkg::FUNC_W-1:0] func;
  logic [sss_pkg::OFF_W-1:0]  off;
  logic [IW-1:0]  before_idx;
  logic [IW-1:0]  best_idx;
  logic           best_valid;
  logic [IW-1:0]  rd_addr;
  logic [MW-1:0]  rd_mean_raw;
  logic [CW-1:0]  rd_cnt_raw;
  logic           rd_vld;
  logic [MW-1:0]  rd_mean;
  logic [CW-1:0]  rd_cnt;
  logic [MW-1:0]  cur_mean;
  logic [CW-1:0]  cur_cnt;
  logic           div_neg;
  logic [sss_pkg::PROD_W-1:0] prod;
  logic           bad_cur;
  logic           good;
  logic [IW-1:0]  scan_i;
  logic [IW-1:0]  last;
  logic           last_valid;
  logic [MW-1:0]  last_mean;
  logic [IW-1:0]  first;

  logic [sss_pkg::OFF_W:0]   abs_x;
  logic [MW+1:0]             diff;
  logic [MW+1:0]             diff_mag;
  logic [CW-1:0]             n_next;
  logic                      div_start;
  logic                      div_busy;
  logic [MW-1:0]             quotient;
  logic [MW-1:0]             new_mean;
  logic                      take_cur;
  logic [MW-1:0]             mul_a;
  logic [CW-1:0]             mul_b;
  logic                      move_ok;
  logic [IW:0]               span;

  assign rd_mean = rd_vld ? rd_mean_raw : '0;
  assign rd_cnt  = rd_vld ? rd_cnt_raw : '0;

  always_comb begin
    case (cmd.op)
      sss_pkg::OP_RD_CUR:  rd_addr = cur_index;
      sss_pkg::OP_RD_BEST: rd_addr = best_idx;
      sss_pkg::OP_RD_MID:  rd_addr = MID;
      sss_pkg::OP_RD_SCAN: rd_addr = scan_i;
      sss_pkg::OP_RD_WALK: rd_addr = first - 1'b1;
      default:             rd_addr = cur_index;
    endcase
  end

  // Sample arithmetic: |x| - mean, split into sign and magnitude for the divider.
  assign abs_x    = off[sss_pkg::OFF_W-1] ? ({1'b0, ~off} + 1'b1) : {1'b0, off};
  assign diff     = {1'b0, abs_x} - {2'b00, rd_mean};
  assign diff_mag = diff[MW+1] ? (~diff + 1'b1) : diff;
  assign n_next   = (rd_cnt == sss_pkg::CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
  assign div_start = cmd.op == sss_pkg::OP_DIV;
  assign new_mean  = div_neg ? cur_mean - quotient : cur_mean + quotient;

  sss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_mag[MW-1:0]),
    .divisor  (n_next),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign take_cur = !best_valid || (cur_mean < rd_mean);

  always_comb begin
    mul_a = cur_mean;
    mul_b = cur_cnt;
    if (cmd.op == sss_pkg::OP_MUL_RD ||
        (cmd.op == sss_pkg::OP_UPD_BEST && !take_cur)) begin
      mul_a = rd_mean;
      mul_b = rd_cnt;
    end
  end

  assign move_ok = !good || !bad_cur;
  assign span    = {1'b0, last} + 1'b1 - {1'b0, first};

  always_comb begin
    stat.func       = func;
    stat.fin        = finished;
    stat.div_busy   = div_busy;
    stat.prod_bad   = prod > {{(sss_pkg::PROD_W-sss_pkg::LIM_W){1'b0}}, bad_limit};
    stat.tries_hit  = cur_cnt >= tries;
    stat.cur_hi     = cur_index >= MID;
    stat.can_up     = (cur_index < TOP) && move_ok;
    stat.can_down   = (cur_index != '0) && move_ok;
    stat.not_good   = !good;
    stat.scan_last  = scan_i == TOP;
    stat.first_zero = first == '0;
    stat.walk_match = (rd_cnt != '0) && (rd_mean == last_mean);
  end

  assign moved = cur_index != before_idx;

  always_ff @(posedge clk) begin
    if (cmd.op == sss_pkg::OP_WRITE) begin
      mean_mem[cur_index] <= new_mean;
      cnt_mem[cur_index]  <= cur_cnt;
    end
    rd_mean_raw <= mean_mem[rd_addr];
    rd_cnt_raw  <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (cmd.op == sss_pkg::OP_CLEAR) begin
        vld <= '0;
      end else if (cmd.op == sss_pkg::OP_WRITE) begin
        vld[cur_index] <= 1'b1;
      end
    end
  end

  // Search state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_index  <= MID;
      best_idx   <= '0;
      best_valid <= 1'b0;
      finished   <= 1'b0;
      bad_cur    <= 1'b0;
      good       <= 1'b0;
    end else begin
      case (cmd.op)
        sss_pkg::OP_CLEAR: begin
          cur_index  <= MID;
          best_idx   <= '0;
          best_valid <= 1'b0;
          finished   <= func == sss_pkg::FUNC_BEGIN_DONE;
        end
        sss_pkg::OP_CHK_CUR:   bad_cur <= stat.prod_bad;
        sss_pkg::OP_UPD_BEST: begin
          if (take_cur) begin
            best_idx   <= cur_index;
            best_valid <= 1'b1;
          end
        end
        sss_pkg::OP_CHK_BEST:  good <= !stat.prod_bad;
        sss_pkg::OP_STEP_UP:   cur_index <= cur_index + 1'b1;
        sss_pkg::OP_STEP_DOWN: cur_index <= cur_index - 1'b1;
        sss_pkg::OP_STEP_MID:  cur_index <= IW'(sss_pkg::MID_INDEX - 1);
        sss_pkg::OP_FINAL: begin
          cur_index <= first + span[IW:1];
          finished  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Working registers of one transaction.
  always_ff @(posedge clk) begin
    case (cmd.op)
      sss_pkg::OP_ACCEPT: begin
        func       <= in_func;
        off        <= in_offset;
        before_idx <= cur_index;
      end
      sss_pkg::OP_DIV: begin
        cur_mean <= rd_mean;
        cur_cnt  <= n_next;
        div_neg  <= diff[MW+1];
      end
      sss_pkg::OP_WRITE:    cur_mean <= new_mean;
      sss_pkg::OP_MUL_CUR,
      sss_pkg::OP_UPD_BEST,
      sss_pkg::OP_MUL_RD:   prod <= sss_pkg::PROD_W'(mul_a) * sss_pkg::PROD_W'(mul_b);
      sss_pkg::OP_SCAN_INIT: begin
        scan_i     <= '0;
        last_valid <= 1'b0;
      end
      sss_pkg::OP_SCAN_STEP: begin
        if (rd_cnt != '0 && (!last_valid || rd_mean <= last_mean)) begin
          last       <= scan_i;
          last_mean  <= rd_mean;
          last_valid <= 1'b1;
        end
        scan_i <= scan_i + 1'b1;
      end
      sss_pkg::OP_WALK_INIT: begin
        if (last_valid) begin
          first <= last;
        end else begin
          last      <= cur_index;
          last_mean <= cur_mean;
          first     <= cur_index;
        end
      end
      sss_pkg::OP_WALK_DEC: first <= first - 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/sss_ctrl.sv =====
// Controller state machine that sequences the datapath for each transaction.
module sss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sss_pkg::dp_stat_t stat,
  output sss_pkg::dp_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DISPATCH  = 5'd1;
  localparam logic [4:0] S_DIV_GO    = 5'd2;
  localparam logic [4:0] S_DIV_WAIT  = 5'd3;
  localparam logic [4:0] S_MUL_CUR   = 5'd4;
  localparam logic [4:0] S_CHK_CUR   = 5'd5;
  localparam logic [4:0] S_RD_BEST   = 5'd6;
  localparam logic [4:0] S_UPD_BEST  = 5'd7;
  localparam logic [4:0] S_CHK_BEST  = 5'd8;
  localparam logic [4:0] S_DECIDE    = 5'd9;
  localparam logic [4:0] S_MID_MUL   = 5'd10;
  localparam logic [4:0] S_MID_CHK   = 5'd11;
  localparam logic [4:0] S_SCAN_INIT = 5'd12;
  localparam logic [4:0] S_SCAN_RD   = 5'd13;
  localparam logic [4:0] S_SCAN_CHK  = 5'd14;
  localparam logic [4:0] S_WALK_INIT = 5'd15;
  localparam logic [4:0] S_WALK_TEST = 5'd16;
  localparam logic [4:0] S_WALK_CHK  = 5'd17;
  localparam logic [4:0] S_FINAL     = 5'd18;
  localparam logic [4:0] S_OUT       = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = sss_pkg::OP_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = sss_pkg::OP_ACCEPT;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_OUT;
        case (stat.func)
          sss_pkg::FUNC_BEGIN,
          sss_pkg::FUNC_BEGIN_DONE: cmd.op = sss_pkg::OP_CLEAR;
          sss_pkg::FUNC_SAMPLE: begin
            if (!stat.fin) begin
              cmd.op     = sss_pkg::OP_RD_CUR;
              state_next = S_DIV_GO;
            end
          end
          default: ;
        endcase
      end
      S_DIV_GO: begin
        cmd.op     = sss_pkg::OP_DIV;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = sss_pkg::OP_WRITE;
          state_next = S_MUL_CUR;
        end
      end
      S_MUL_CUR: begin
        cmd.op     = sss_pkg::OP_MUL_CUR;
        state_next = S_CHK_CUR;
      end
      S_CHK_CUR: begin
        cmd.op     = sss_pkg::OP_CHK_CUR;
        state_next = (stat.prod_bad || stat.tries_hit) ? S_RD_BEST : S_OUT;
      end
      S_RD_BEST: begin
        cmd.op     = sss_pkg::OP_RD_BEST;
        state_next = S_UPD_BEST;
      end
      S_UPD_BEST: begin
        cmd.op     = sss_pkg::OP_UPD_BEST;
        state_next = S_CHK_BEST;
      end
      S_CHK_BEST: begin
        cmd.op     = sss_pkg::OP_CHK_BEST;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.cur_hi) begin
          if (stat.can_up) begin
            cmd.op     = sss_pkg::OP_STEP_UP;
            state_next = S_OUT;
          end else if (sss_pkg::MID_INDEX > 0) begin
            cmd.op     = sss_pkg::OP_RD_MID;
            state_next = S_MID_MUL;
          end else begin
            state_next = S_SCAN_INIT;
          end
        end else if (stat.can_down) begin
          cmd.op     = sss_pkg::OP_STEP_DOWN;
          state_next = S_OUT;
        end else begin
          state_next = S_SCAN_INIT;
        end
      end
      S_MID_MUL: begin
        cmd.op     = sss_pkg::OP_MUL_RD;
        state_next = S_MID_CHK;
      end
      S_MID_CHK: begin
        if (stat.not_good || !stat.prod_bad) begin
          cmd.op     = sss_pkg::OP_STEP_MID;
          state_next = S_OUT;
        end else begin
          state_next = S_SCAN_INIT;
        end
      end
      S_SCAN_INIT: begin
        cmd.op     = sss_pkg::OP_SCAN_INIT;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.op     = sss_pkg::OP_RD_SCAN;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.op     = sss_pkg::OP_SCAN_STEP;
        state_next = stat.scan_last ? S_WALK_INIT : S_SCAN_RD;
      end
      S_WALK_INIT: begin
        cmd.op     = sss_pkg::OP_WALK_INIT;
        state_next = S_WALK_TEST;
      end
      S_WALK_TEST: begin
        if (stat.first_zero) begin
          state_next = S_FINAL;
        end else begin
          cmd.op     = sss_pkg::OP_RD_WALK;
          state_next = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (stat.walk_match) begin
          cmd.op     = sss_pkg::OP_WALK_DEC;
          state_next = S_WALK_TEST;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.op     = sss_pkg::OP_FINAL;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/stall_sensitivity_search_top.sv =====
// Top level: configuration registers, channel handshakes, controller and datapath.
// Begin and ignored transactions skip the arithmetic. A sample waits on the 16-step divider,
// and one that moves on or drops below the middle also checks the best setting. A sample that
// ends the search also runs the table scan and final pick, which walk back over tied settings.
// Throughput: one at a time; the next is taken the cycle after the result is taken.
// Reset (rst, synchronous): tables read as zero, setting at the middle, registers at defaults.
module stall_sensitivity_search_top (
  input  logic                              clk,
  input  logic                              rst,
  sss_cmd_if.sink                           cmd,
  sss_rsp_if.source                         rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sss_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [sss_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [sss_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [sss_pkg::LIM_W-1:0] bad_limit;
  logic [sss_pkg::TRY_W-1:0] tries;
  logic                      cfg_wr;
  sss_pkg::dp_cmd_t          dp_cmd;
  sss_pkg::dp_stat_t         dp_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_limit <= sss_pkg::BAD_LIMIT_RST;
      tries     <= sss_pkg::TRIES_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        sss_pkg::REG_BAD_LIMIT: bad_limit <= pwdata[sss_pkg::LIM_W-1:0];
        sss_pkg::REG_TRIES:     tries     <= pwdata[sss_pkg::TRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sss_pkg::REG_BAD_LIMIT: prdata = {{(sss_pkg::APB_DATA_W-sss_pkg::LIM_W){1'b0}}, bad_limit};
      sss_pkg::REG_TRIES:     prdata = {{(sss_pkg::APB_DATA_W-sss_pkg::TRY_W){1'b0}}, tries};
      default:                prdata = '0;
    endcase
  end

  sss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  sss_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .in_func   (cmd.func),
    .in_offset (cmd.homing_offset),
    .bad_limit (bad_limit),
    .tries     (tries),
    .cur_index (rsp.sensitivity_index),
    .finished  (rsp.done_res),
    .moved     (rsp.moved)
  );

endmodule

// ===== rtl/core/sss_checker.sv =====
// Port-level checker of the stall sensitivity search, bound to the top level.
module sss_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [sss_pkg::IDX_W-1:0]  rsp_index,
  input logic                       rsp_done,
  input logic                       rsp_moved
);

  // No result may be offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result offered after reset");

  // One transaction at a time: nothing is taken while a result waits.
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !cmd_ready)
    else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("input ready right after a transaction");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_index) && $stable(rsp_done) && $stable(rsp_moved)))
    else $error("stalled result changed");

endmodule

bind stall_sensitivity_search_top sss_checker u_sss_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_index (rsp.sensitivity_index),
  .rsp_done  (rsp.done_res),
  .rsp_moved (rsp.moved)
);
